@@ rtl/modexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Register indexes, microcode word format and the sequencer program.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 2'd1;

  localparam int PC_BITS = 4;

  // Datapath operation of one microcode step.
  typedef enum logic [3:0] {
    UOP_WAIT,      // idle; capture base and exponent on a new transaction
    UOP_LOAD_RED,  // set up base reduction: multiplicand 1, product 0
    UOP_RUN,       // one double-and-add step of the shared reduction unit
    UOP_SET_ONE,   // keep reduced base, set accumulator to 1 mod m
    UOP_LOAD_SQR,  // set up acc * acc
    UOP_LOAD_MUL,  // set up acc * base
    UOP_STORE,     // copy product into the accumulator
    UOP_NEXT_BIT,  // advance to the next exponent bit
    UOP_EMIT,      // drive the result
    UOP_EMIT_ERR   // drive the zero-modulus error result
  } uop_t;

  // Jump condition: taken -> pc = target, else pc + 1.
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_START,
    COND_MOD_ZERO,
    COND_RUN_BUSY,
    COND_EBIT_CLR,
    COND_MORE_BITS
  } cond_t;

  typedef struct packed {
    uop_t               uop;
    cond_t              cond;
    logic [PC_BITS-1:0] target;
  } uinstr_t;

  localparam logic [PC_BITS-1:0] PC_WAIT     = 4'd0;
  localparam logic [PC_BITS-1:0] PC_LOAD_RED = 4'd1;
  localparam logic [PC_BITS-1:0] PC_RUN_RED  = 4'd2;
  localparam logic [PC_BITS-1:0] PC_SET_ONE  = 4'd3;
  localparam logic [PC_BITS-1:0] PC_LOAD_SQR = 4'd4;
  localparam logic [PC_BITS-1:0] PC_RUN_SQR  = 4'd5;
  localparam logic [PC_BITS-1:0] PC_STORE_SQ = 4'd6;
  localparam logic [PC_BITS-1:0] PC_LOAD_MUL = 4'd7;
  localparam logic [PC_BITS-1:0] PC_RUN_MUL  = 4'd8;
  localparam logic [PC_BITS-1:0] PC_STORE_ML = 4'd9;
  localparam logic [PC_BITS-1:0] PC_NEXT_BIT = 4'd10;
  localparam logic [PC_BITS-1:0] PC_EMIT     = 4'd11;
  localparam logic [PC_BITS-1:0] PC_EMIT_ERR = 4'd12;

  // Sequencer program ROM.
  function automatic uinstr_t ucode(input logic [PC_BITS-1:0] pc);
    uinstr_t w;
    unique case (pc)
      PC_WAIT:     w = '{UOP_WAIT,     COND_NO_START,  PC_WAIT};
      PC_LOAD_RED: w = '{UOP_LOAD_RED, COND_MOD_ZERO,  PC_EMIT_ERR};
      PC_RUN_RED:  w = '{UOP_RUN,      COND_RUN_BUSY,  PC_RUN_RED};
      PC_SET_ONE:  w = '{UOP_SET_ONE,  COND_NONE,      PC_WAIT};
      PC_LOAD_SQR: w = '{UOP_LOAD_SQR, COND_NONE,      PC_WAIT};
      PC_RUN_SQR:  w = '{UOP_RUN,      COND_RUN_BUSY,  PC_RUN_SQR};
      PC_STORE_SQ: w = '{UOP_STORE,    COND_EBIT_CLR,  PC_NEXT_BIT};
      PC_LOAD_MUL: w = '{UOP_LOAD_MUL, COND_NONE,      PC_WAIT};
      PC_RUN_MUL:  w = '{UOP_RUN,      COND_RUN_BUSY,  PC_RUN_MUL};
      PC_STORE_ML: w = '{UOP_STORE,    COND_NONE,      PC_WAIT};
      PC_NEXT_BIT: w = '{UOP_NEXT_BIT, COND_MORE_BITS, PC_LOAD_SQR};
      PC_EMIT:     w = '{UOP_EMIT,     COND_ALWAYS,    PC_WAIT};
      PC_EMIT_ERR: w = '{UOP_EMIT_ERR, COND_ALWAYS,    PC_WAIT};
      default:     w = '{UOP_WAIT,     COND_ALWAYS,    PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation
// base_value ** exponent mod modulus by left-to-right square-and-multiply.
// ----------------------------------------------------------------------------
// Usage: write exponent (index 0) and modulus (index 1) through the cfg
// channel while busy and start are low, then pulse start with base_value.
// busy rises on the cycle after the transaction is taken and falls as done
// pulses for one cycle with power_result and modulus_error; the receiver
// cannot stall, so sample the result in that cycle. A zero modulus gives
// result 0 with modulus_error set. Otherwise the base is reduced mod m, then
// every exponent bit, MSB first, gets a square and, when the bit is set, a
// multiply by the reduced base. The single modular double-and-add unit,
// which retires one multiplier bit per cycle, is shared by base reduction,
// squaring and multiplication under a microcoded sequencer.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int WORD_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [modexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]                cfg_data,
  // command side
  input  logic                                start,
  output logic                                busy,
  input  logic [WORD_BITS-1:0]                base_value,
  // result side
  output logic                                done,
  output logic [WORD_BITS-1:0]                power_result,
  output logic                                modulus_error
);
  import modexp_pkg::*;

  localparam int CNT_BITS = $clog2(WORD_BITS);
  localparam int TW       = WORD_BITS + 2;
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

  // Configuration registers
  logic [WORD_BITS-1:0] exponent;
  logic [WORD_BITS-1:0] modulus;

  // Sequencer
  logic [PC_BITS-1:0] pc;
  logic [PC_BITS-1:0] pc_next;
  uinstr_t            uinstr;
  logic               jump;

  // Datapath
  logic [WORD_BITS-1:0] ereg;      // exponent bits, MSB is the current one
  logic [WORD_BITS-1:0] breg;      // multiplier bits, MSB is the current one
  logic [WORD_BITS-1:0] mcand;     // multiplicand
  logic [WORD_BITS-1:0] base_red;  // base mod m
  logic [WORD_BITS-1:0] acc;       // running power
  logic [WORD_BITS-1:0] prod;      // partial product
  logic [CNT_BITS-1:0]  cnt;       // multiplier bit counter
  logic [CNT_BITS-1:0]  bitcnt;    // exponent bit counter

  logic [TW-1:0]        sum;
  logic [TW-1:0]        mod1;
  logic [TW-1:0]        mod2;
  logic [WORD_BITS-1:0] prod_next;

  // Hold off key writes at the edge that takes a transaction, so both keys
  // seen by that transaction come from the same point in time.
  assign cfg_ready = !busy && !start;
  assign busy      = (pc != PC_WAIT);
  assign uinstr    = ucode(pc);

  // Register file: writes to unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= '0;
      modulus  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_EXPONENT) begin
        exponent <= cfg_data;
      end else if (cfg_index == REG_MODULUS) begin
        modulus <= cfg_data;
      end
    end
  end

  // Jump condition decode
  always_comb begin
    unique case (uinstr.cond)
      COND_NONE:      jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NO_START:  jump = !start;
      COND_MOD_ZERO:  jump = (modulus == '0);
      COND_RUN_BUSY:  jump = (cnt != CNT_LAST);
      COND_EBIT_CLR:  jump = !ereg[WORD_BITS-1];
      COND_MORE_BITS: jump = (bitcnt != CNT_LAST);
      default:        jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = jump ? uinstr.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // Shared modular double-and-add: prod' = (2*prod + bit*mcand) mod m.
  // With prod, mcand < m the sum stays below 3m, so one of two subtracts
  // brings it back into range.
  always_comb begin
    sum  = {1'b0, prod, 1'b0} + {2'b00, (breg[WORD_BITS-1] ? mcand : '0)};
    mod1 = {2'b00, modulus};
    mod2 = {1'b0, modulus, 1'b0};
    if (sum >= mod2) begin
      prod_next = WORD_BITS'(sum - mod2);
    end else if (sum >= mod1) begin
      prod_next = WORD_BITS'(sum - mod1);
    end else begin
      prod_next = WORD_BITS'(sum);
    end
  end

  always_ff @(posedge clk) begin
    unique case (uinstr.uop)
      UOP_WAIT: begin
        if (start) begin
          breg   <= base_value;
          ereg   <= exponent;
          bitcnt <= '0;
        end
      end
      UOP_LOAD_RED: begin
        // Reduce the base by feeding its bits through with multiplicand 1.
        mcand <= WORD_BITS'(1);
        prod  <= '0;
        cnt   <= '0;
      end
      UOP_RUN: begin
        prod <= prod_next;
        breg <= breg << 1;
        cnt  <= cnt + 1'b1;
      end
      UOP_SET_ONE: begin
        base_red <= prod;
        acc      <= (modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
      end
      UOP_LOAD_SQR: begin
        mcand <= acc;
        breg  <= acc;
        prod  <= '0;
        cnt   <= '0;
      end
      UOP_LOAD_MUL: begin
        mcand <= acc;
        breg  <= base_red;
        prod  <= '0;
        cnt   <= '0;
      end
      UOP_STORE: begin
        acc <= prod;
      end
      UOP_NEXT_BIT: begin
        ereg   <= ereg << 1;
        bitcnt <= bitcnt + 1'b1;
      end
      UOP_EMIT: begin
        power_result  <= acc;
        modulus_error <= 1'b0;
      end
      UOP_EMIT_ERR: begin
        power_result  <= '0;
        modulus_error <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result strobe: registered, so it rises in the cycle after an emit step.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (uinstr.uop == UOP_EMIT) || (uinstr.uop == UOP_EMIT_ERR);
    end
  end

endmodule

@@ rtl/modexp_checker.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level properties of the command and result sides, bound to the top.
// ----------------------------------------------------------------------------
module modexp_checker #(
  parameter int WORD_BITS = 64
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [WORD_BITS-1:0] power_result,
  input logic                 modulus_error
);

  // An accepted transaction makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transaction");

  // The result strobe lasts one cycle and never overlaps busy.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done asserted while busy");

  // Leaving busy outside reset always delivers a result.
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy fell without a result");

  // Error results carry zero.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && modulus_error) |-> (power_result == '0))
    else $error("error result is not zero");

endmodule

bind modular_exponentiation modexp_checker #(.WORD_BITS(WORD_BITS)) u_modexp_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .power_result  (power_result),
  .modulus_error (modulus_error)
);

@@ verif/tb_modular_exponentiation.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base values through the command port under a series of key settings
// written on the cfg channel. An exact square-and-multiply predictor computes
// each expected power, and the monitor checks every done pulse in order.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;

  import modexp_pkg::*;

  localparam int WORD_BITS = 64;

  // Index values the block does not decode; writes to them must be dropped.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

  localparam logic [WORD_BITS-1:0] ALL_ONES = '1;
  localparam logic [WORD_BITS-1:0] TOP_BIT  = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam int                   MAX_REPORTS = 10;

  typedef struct packed {
    logic [WORD_BITS-1:0] power;
    logic                 err;
  } power_entry_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [WORD_BITS-1:0]      cfg_data = '0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [WORD_BITS-1:0]      base_value = '0;
  logic                      done;
  logic [WORD_BITS-1:0]      power_result;
  logic                      modulus_error;

  // Key registers as the block should hold them; both clear on reset.
  logic [WORD_BITS-1:0] key_exponent = '0;
  logic [WORD_BITS-1:0] key_modulus  = '0;

  logic [WORD_BITS-1:0] pending_bases[$];
  power_entry_t         expected_powers[$];
  int unsigned          send_idle_pct = 0;
  logic                 base_taken = 1'b0;
  int unsigned          mismatch_count = 0;

  modular_exponentiation #(
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .base_value   (base_value),
    .done         (done),
    .power_result (power_result),
    .modulus_error(modulus_error)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Exact (a * b) mod m through a double-width product.
  function automatic logic [WORD_BITS-1:0] mul_mod_exact(
    input logic [WORD_BITS-1:0] a,
    input logic [WORD_BITS-1:0] b,
    input logic [WORD_BITS-1:0] m
  );
    logic [2*WORD_BITS-1:0] prod;
    prod = {{WORD_BITS{1'b0}}, a} * {{WORD_BITS{1'b0}}, b};
    return WORD_BITS'(prod % {{WORD_BITS{1'b0}}, m});
  endfunction

  // Left-to-right square-and-multiply over every exponent bit, base reduced
  // first. A zero modulus short-circuits to the error result.
  function automatic power_entry_t predict_power(input logic [WORD_BITS-1:0] base);
    power_entry_t         res;
    logic [WORD_BITS-1:0] reduced;
    logic [WORD_BITS-1:0] acc;
    res = '0;
    if (key_modulus == '0) begin
      res.err = 1'b1;
      return res;
    end
    reduced = base % key_modulus;
    acc     = WORD_BITS'(1) % key_modulus;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      acc = mul_mod_exact(acc, acc, key_modulus);
      if (key_exponent[i]) begin
        acc = mul_mod_exact(acc, reduced, key_modulus);
      end
    end
    res.power = acc;
    return res;
  endfunction

  // Append a base to the driver's queue.
  task automatic queue_base(input logic [WORD_BITS-1:0] b);
    pending_bases = {pending_bases, b};
  endtask

  // --------------------------------------------------------------------------
  // Driver: raise start with the next pending base at the falling edge. Hold
  // start and the base until the transaction is taken, then either advance to
  // the next base or drop start, for an idle slot or once the queue is empty.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || base_taken) begin
      if (pending_bases.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        start      <= 1'b1;
        base_value <= pending_bases.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the block's own
  // registers update. Track key writes, predict on every accepted base and
  // check each done pulse against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: mismatch: %s", $realtime, what);
    end
  endtask

  always @(posedge clk) begin
    power_entry_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EXPONENT: key_exponent = cfg_data;
          REG_MODULUS:  key_modulus  = cfg_data;
          default: ;  // undecoded index, block drops the write
        endcase
      end

      base_taken = start && !busy;
      if (base_taken) begin
        expected_powers = {expected_powers, predict_power(base_value)};
      end

      if (done) begin
        if (expected_powers.size() == 0) begin
          flag_mismatch($sformatf("result %h err %b with nothing outstanding",
                                  power_result, modulus_error));
        end else begin
          want = expected_powers.pop_front();
          if (power_result !== want.power) begin
            flag_mismatch($sformatf("power_result expected %h actual %h",
                                    want.power, power_result));
          end
          if (modulus_error !== want.err) begin
            flag_mismatch($sformatf("modulus_error expected %b actual %b",
                                    want.err, modulus_error));
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing helpers
  // --------------------------------------------------------------------------

  // Wait until every queued base has gone through and every result is back.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending_bases.size() != 0 || start || busy ||
               expected_powers.size() != 0);
  endtask

  // One cfg transaction; wait for ready, then drop valid.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [WORD_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Switch keys once the block has gone quiet.
  task automatic load_key(input logic [WORD_BITS-1:0] e, input logic [WORD_BITS-1:0] m);
    drain();
    write_reg(REG_EXPONENT, e);
    write_reg(REG_MODULUS, m);
  endtask

  function automatic logic [WORD_BITS-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_exponent();
    case ($urandom_range(5))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return WORD_BITS'($urandom_range(1, 16));
      default: return rand_word();
    endcase
  endfunction

  // Modulus zero is rare and cheap; powers of two and tiny values hit the
  // reduction corner cases.
  function automatic logic [WORD_BITS-1:0] pick_modulus();
    case ($urandom_range(7))
      0:       return '0;
      1:       return WORD_BITS'(1);
      2:       return ALL_ONES;
      3:       return WORD_BITS'(1) << $urandom_range(WORD_BITS - 1);
      4:       return WORD_BITS'($urandom_range(2, 1000));
      default: return rand_word();
    endcase
  endfunction

  // Bases clustered around the modulus, plus the extremes.
  function automatic logic [WORD_BITS-1:0] pick_base(input logic [WORD_BITS-1:0] m);
    case ($urandom_range(9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return m - 1;
      3:       return m;
      4:       return m + 1;
      default: return rand_word();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned idle_plan[4];
    logic [WORD_BITS-1:0] e;
    logic [WORD_BITS-1:0] m;

    idle_plan = '{0, 78, 0, 17};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Keys still at their reset value: zero modulus reports an error.
    queue_base('0);
    queue_base(ALL_ONES);

    // Zero exponent gives 1 mod m, which is 0 when the modulus is one.
    load_key('0, ALL_ONES);
    queue_base('0);
    queue_base(WORD_BITS'(7));
    load_key('0, WORD_BITS'(1));
    queue_base(WORD_BITS'(123));

    // Every exponent bit set, largest modulus.
    load_key(ALL_ONES, ALL_ONES);
    queue_base('0);
    queue_base(WORD_BITS'(1));
    queue_base(ALL_ONES);
    queue_base(ALL_ONES - 1);
    queue_base(WORD_BITS'(2));

    // Undecoded indexes must leave both keys alone.
    drain();
    write_reg(REG_SPARE_LO, WORD_BITS'(5));
    write_reg(REG_SPARE_HI, '0);
    queue_base(WORD_BITS'(3));

    // Common public exponent with the largest 64-bit prime as modulus.
    load_key(WORD_BITS'(65537), 64'hFFFF_FFFF_FFFF_FFC5);
    queue_base(WORD_BITS'(2));
    queue_base(64'h0123_4567_89AB_CDEF);
    queue_base(ALL_ONES);

    // Identity exponent: result is just the reduced base.
    load_key(WORD_BITS'(1), TOP_BIT);
    queue_base(ALL_ONES);
    queue_base(TOP_BIT);

    // Only the top exponent bit set.
    load_key(TOP_BIT, WORD_BITS'(3));
    queue_base(WORD_BITS'(2));

    // Modulus cleared again after a valid key.
    load_key(WORD_BITS'(5), '0);
    queue_base(WORD_BITS'(9));

    load_key(WORD_BITS'(2), WORD_BITS'(2));
    queue_base(WORD_BITS'(1));

    // Random keys, a dozen bases each, rotating through the idle patterns.
    for (int phase = 0; phase < 8; phase++) begin
      e = pick_exponent();
      m = pick_modulus();
      load_key(e, m);
      send_idle_pct = idle_plan[phase % 4];
      for (int k = 0; k < 12; k++) begin
        queue_base(pick_base(m));
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && expected_powers.size() == 0) begin
      $display("[modular_exponentiation] OK");
    end else begin
      $display("[modular_exponentiation] ERROR");
    end
    $finish;
  end

  // Guard against a hang: several times the slowest correct run.
  initial begin
    #50_000_000;
    $display("[modular_exponentiation] ERROR");
    $finish;
  end

endmodule
